// ===== hdl/sfd_pkg.sv =====
// shared types, constants and helpers for the sensor frame deframer
package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE  = 8'hEE;

  // position constants within a frame
  localparam int unsigned POS_W       = 6;
  localparam int unsigned SYNC_NEEDED = 3;
  localparam logic [POS_W-1:0] CMD_POS  = 6'd3;
  localparam logic [POS_W-1:0] SUM_POS  = 6'd44;
  localparam logic [POS_W-1:0] WORD_POS = 6'd4;
  localparam logic [POS_W-1:0] VER_POS0 = 6'd5;
  localparam logic [POS_W-1:0] VER_POS1 = 6'd12;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VALUE_W = 48;
  localparam int unsigned TDATA_W = 56;
  localparam int unsigned TUSER_W = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMU     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SONAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

  typedef enum logic [1:0] {
    KIND_IMU     = 2'd0,
    KIND_SONAR   = 2'd1,
    KIND_VERSION = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_WORD_RD,
    S_WORD_ACC,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    logic  go;
    kind_e kind;
  } seq_start_t;

  function automatic logic [IDX_W-1:0] last_index(kind_e kind);
    logic [IDX_W-1:0] r;
    case (kind)
      KIND_IMU:     r = 4'd9;
      KIND_SONAR:   r = 4'd3;
      KIND_VERSION: r = 4'd1;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

  // index of the final byte within one word
  function automatic logic [2:0] last_byte(kind_e kind);
    logic [2:0] r;
    case (kind)
      KIND_VERSION: r = 3'd5;
      default:      r = 3'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sfd_ram.sv =====
// generic simple dual-port ram with registered read
module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfd_seq.sv =====
// frame emit sequencer: byte-serial checksum and word assembly over the buffer
module sfd_seq #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfd_pkg::seq_start_t               start_i,
  input  logic [$clog2(BUFFER_DEPTH+1)-1:0] limit_i,
  output logic                              busy_o,
  output logic                              rd_en_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   rd_addr_o,
  input  logic [7:0]                        rd_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sfd_pkg::kind_e                    out_kind_o,
  output logic                              out_ok_o,
  output logic [sfd_pkg::IDX_W-1:0]         out_idx_o,
  output logic [sfd_pkg::VALUE_W-1:0]       out_value_o,
  output logic                              out_last_o
);
  import sfd_pkg::*;

  localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  seq_state_e         state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [2:0]         nbyte_q, nbyte_d;
  logic [IDX_W-1:0]   widx_q, widx_d;
  logic [7:0]         sum_q, sum_d;
  logic               ok_q, ok_d;
  kind_e              kind_q, kind_d;
  logic [LW-1:0]      limit_q, limit_d;
  logic [VALUE_W-1:0] word_q, word_d;
  logic               hit_q, hit_d;
  logic [7:0]         byte_v;
  logic               is_last;

  // bytes past the fill point read as zero
  assign byte_v  = hit_q ? rd_data_i : 8'h00;
  assign is_last = (widx_q == last_index(kind_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    nbyte_q <= nbyte_d;
    widx_q  <= widx_d;
    sum_q   <= sum_d;
    ok_q    <= ok_d;
    kind_q  <= kind_d;
    limit_q <= limit_d;
    word_q  <= word_d;
    hit_q   <= hit_d;
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    nbyte_d   = nbyte_q;
    widx_d    = widx_q;
    sum_d     = sum_q;
    ok_d      = ok_q;
    kind_d    = kind_q;
    limit_d   = limit_q;
    word_d    = word_q;
    hit_d     = hit_q;
    rd_en_o   = 1'b0;
    rd_addr_o = AW'(pos_q);
    case (state_q)
      S_IDLE: begin
        if (start_i.go) begin
          kind_d  = start_i.kind;
          limit_d = limit_i;
          sum_d   = 8'h00;
          ok_d    = 1'b1;
          nbyte_d = 3'd0;
          widx_d  = '0;
          word_d  = '0;
          case (start_i.kind)
            KIND_IMU: begin
              pos_d   = CMD_POS;
              state_d = S_SUM_RD;
            end
            KIND_VERSION: begin
              pos_d   = VER_POS0;
              state_d = S_WORD_RD;
            end
            default: begin
              pos_d   = WORD_POS;
              state_d = S_WORD_RD;
            end
          endcase
        end
      end
      S_SUM_RD: begin
        rd_en_o = 1'b1;
        hit_d   = (LW'(pos_q) < limit_q);
        state_d = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        if (pos_q == SUM_POS) begin
          ok_d    = (sum_q == byte_v);
          pos_d   = WORD_POS;
          state_d = S_WORD_RD;
        end else begin
          sum_d   = sum_q + byte_v;
          pos_d   = pos_q + 1'b1;
          state_d = S_SUM_RD;
        end
      end
      S_WORD_RD: begin
        rd_en_o = 1'b1;
        hit_d   = (LW'(pos_q) < limit_q);
        state_d = S_WORD_ACC;
      end
      S_WORD_ACC: begin
        word_d[{nbyte_q, 3'b000} +: 8] = byte_v;
        pos_d = pos_q + 1'b1;
        if (nbyte_q == last_byte(kind_q)) begin
          state_d = S_OUT;
        end else begin
          nbyte_d = nbyte_q + 1'b1;
          state_d = S_WORD_RD;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            widx_d  = widx_q + 1'b1;
            nbyte_d = 3'd0;
            word_d  = '0;
            // version words are not contiguous
            if (kind_q == KIND_VERSION) begin
              pos_d = VER_POS1;
            end
            state_d = S_WORD_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_kind_o  = kind_q;
  assign out_ok_o    = ok_q;
  assign out_idx_o   = widx_q;
  assign out_value_o = word_q;
  assign out_last_o  = is_last;

endmodule

// ===== hdl/sensor_frame_deframer.sv =====
// sensor frame deframer top level: byte parser, frame buffer and emit sequencer
//
// Input stream s_axis carries one received serial byte per transaction. While
// hunting, only 0xAA bytes are kept; the third opens a frame and the byte after
// it is the command. A frame closes on 0xEE following 0xAA in the stream.
// Output stream m_axis then carries the frame as a burst of words: ten for IMU,
// four for sonar, two for version frames, none for an unknown command. tlast
// marks the final word. Command codes are written through the cfg channel
// (index 0 imu, 1 sonar, 2 version), which is always ready.
// Throughput: one byte per cycle while parsing. On the closing byte of a known
// command the input stalls while one shared byte reader walks the buffer: for
// IMU 42 reads for the checksum and its check byte, then 40 data bytes; 16 data
// bytes for sonar and 12 for version.
// A stalled receiver holds the current word and the input waits.
// Reset returns to hunting with an empty buffer and default command codes.
module sensor_frame_deframer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] rx_byte
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sfd_pkg::TDATA_W-1:0]     m_axis_tdata_o,  // [3:0] word_index, [51:4] word_value
  output logic [sfd_pkg::TUSER_W-1:0]     m_axis_tuser_o,  // [1:0] frame_kind, [2] sum_ok
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import sfd_pkg::*;

  localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [7:0]    imu_cmd_q, sonar_cmd_q, version_cmd_q;
  logic          started_q, started_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    prev_q;

  logic          in_xfer;
  logic          busy;
  logic          wr_en;
  logic [7:0]    cmd_now;
  seq_start_t    start;
  logic [LW-1:0] limit;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  kind_e              out_kind;
  logic               out_ok;
  logic [IDX_W-1:0]   out_idx;
  logic [VALUE_W-1:0] out_value;

  assign s_axis_tready_o = !busy;
  assign in_xfer         = s_axis_tvalid_i && !busy;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_cmd_q     <= 8'd1;
      sonar_cmd_q   <= 8'd2;
      version_cmd_q <= 8'd3;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IMU) begin
        imu_cmd_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_SONAR) begin
        sonar_cmd_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_VERSION) begin
        version_cmd_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      fill_q    <= '0;
      cmd_q     <= 8'h00;
      prev_q    <= 8'h00;
    end else if (in_xfer) begin
      started_q <= started_d;
      fill_q    <= fill_d;
      cmd_q     <= cmd_d;
      prev_q    <= s_axis_tdata_i;
    end
  end

  // command byte may be the current byte when the frame closes on it
  assign cmd_now = (fill_q == LW'(CMD_POS)) ? s_axis_tdata_i : cmd_q;

  always_comb begin
    started_d  = started_q;
    fill_d     = fill_q;
    cmd_d      = cmd_q;
    wr_en      = 1'b0;
    start.go   = 1'b0;
    start.kind = KIND_IMU;
    limit      = fill_q + 1'b1;
    if (!started_q) begin
      if (s_axis_tdata_i == SYNC_BYTE) begin
        wr_en  = in_xfer;
        fill_d = fill_q + 1'b1;
        if (fill_q == LW'(SYNC_NEEDED - 1)) begin
          started_d = 1'b1;
        end
      end
    end else if (fill_q == LW'(BUFFER_DEPTH)) begin
      // no room left: drop the frame and hunt again
      started_d = 1'b0;
      fill_d    = '0;
    end else begin
      wr_en  = in_xfer;
      fill_d = fill_q + 1'b1;
      cmd_d  = cmd_now;
      if (prev_q == SYNC_BYTE && s_axis_tdata_i == END_BYTE) begin
        started_d = 1'b0;
        fill_d    = '0;
        if (cmd_now == imu_cmd_q) begin
          start.go = in_xfer;
        end else if (cmd_now == sonar_cmd_q) begin
          start.go   = in_xfer;
          start.kind = KIND_SONAR;
        end else if (cmd_now == version_cmd_q) begin
          start.go   = in_xfer;
          start.kind = KIND_VERSION;
        end
      end
    end
  end

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sfd_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .limit_i     (limit),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_ok_o    (out_ok),
    .out_idx_o   (out_idx),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(TDATA_W - VALUE_W - IDX_W){1'b0}}, out_value, out_idx};
  assign m_axis_tuser_o = {out_ok, out_kind};

endmodule
